### rtl/mset_pkg.sv
// package for the multi-slot event timer table
// op codes, result kinds and default sizes; no dependencies
package mset_pkg;
    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_TIME_BITS = 48;
    localparam int SLOT_W = 4;
    localparam int PERIOD_W = 32;
    localparam int NOW_W = 48;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESET   = 3'd4,
        OP_QUERY   = 3'd5,
        OP_TICK    = 3'd6,
        OP_UNDEF   = 3'd7
    } op_t;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // one result item
    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot_out;
        logic                ok;
        logic                is_active;
        logic [PERIOD_W-1:0] remaining;
        logic                remaining_units;
        logic                last;
    } result_t;
endpackage

### rtl/mset_ram.sv
// generic single-port ram with registered read
// no dependencies
module mset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/mset_time_unit.sv
// shared time compare unit: elapsed time, due flag and saturated remaining
// depends on mset_pkg
module mset_time_unit
    import mset_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic [TIME_BITS-1:0] now,
    input  logic [TIME_BITS-1:0] start,
    input  logic [PERIOD_W-1:0]  period,
    output logic                 due,
    output logic [PERIOD_W-1:0]  remaining
);
    logic [TIME_BITS-1:0] elapsed;
    logic                 reached;

    always_comb begin
        elapsed   = (now >= start) ? (now - start) : '0;
        reached   = elapsed >= TIME_BITS'(period);
        due       = (now >= start) && reached;
        remaining = reached ? '0 : (period - elapsed[PERIOD_W-1:0]);
    end
endmodule

### rtl/multi_slot_event_timer_table_unit.sv
// top level of the multi-slot event timer table
// sequencer over slot flags and ram; uses mset_pkg, mset_ram, mset_time_unit
// create scans for the first free slot; other ops read the ram, then execute;
// tick checks each slot in turn, waiting on m_tready for expiries; sync reset
// clears used, active and dying flags and the tick counter; one item at a time;
// the per-slot scan via the single ram port and shared time unit sets the rate
module multi_slot_event_timer_table_unit
    import mset_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0] slot[6:3] units[7] duration[39:8] auto_start[40]
    // repeat_mode[41] now_ms[89:42], zero fill to 96
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_out[3:0] ok[4] is_active[5] remaining[37:6] remaining_units[38]
    output logic [39:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast
);
    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W = TIME_BITS + PERIOD_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIND, ST_READ, ST_EXEC, ST_SCAN_RD, ST_SCAN_EV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [NUM_SLOTS-1:0] used_reg, active_reg, dying_reg, repeat_reg, units_reg;
    logic [TIME_BITS-1:0] tick_reg, now_reg;
    op_t                  op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 cunits_reg, cauto_reg, crep_reg;
    logic [PERIOD_W-1:0]  dur_reg;
    logic [CNT_W-1:0]     idx_reg;
    result_t              res_reg;
    logic                 out_v_reg;

    logic                 we;
    logic [IDX_W-1:0]     addr;
    logic [ENT_W-1:0]     wdata, rdata;
    logic [TIME_BITS-1:0] r_start, cur_now;
    logic [PERIOD_W-1:0]  r_period, rem;
    logic                 due, valid_slot;
    logic [IDX_W-1:0]     sidx, iidx;
    logic                 exec_used, exec_ok, q_act, expire;

    assign sidx       = IDX_W'(slot_reg);
    assign iidx       = idx_reg[IDX_W-1:0];
    assign valid_slot = 32'(slot_reg) < NUM_SLOTS;
    assign r_start    = rdata[ENT_W-1:PERIOD_W];
    assign r_period   = rdata[PERIOD_W-1:0];
    assign expire     = used_reg[iidx] && !dying_reg[iidx] && active_reg[iidx] && due;

    mset_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SLOTS)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    mset_time_unit #(.TIME_BITS(TIME_BITS)) u_time (
        .now(cur_now), .start(r_start), .period(r_period),
        .due(due), .remaining(rem)
    );

    // op decode for the addressed slot
    always_comb begin
        exec_used = valid_slot && used_reg[sidx];
        q_act     = (op_reg == OP_QUERY) && exec_used && active_reg[sidx];
        unique case (op_reg)
            OP_DESTROY: exec_ok = exec_used;
            OP_START:   exec_ok = exec_used && !active_reg[sidx];
            OP_STOP:    exec_ok = exec_used && active_reg[sidx];
            OP_RESET:   exec_ok = exec_used && active_reg[sidx];
            OP_QUERY:   exec_ok = exec_used;
            default:    exec_ok = 1'b0;
        endcase
    end

    always_comb begin
        we      = 1'b0;
        addr    = sidx;
        cur_now = units_reg[sidx] ? now_reg : tick_reg;
        wdata   = {cur_now, r_period};
        unique case (state_reg)
            ST_FIND: begin
                addr    = iidx;
                cur_now = cunits_reg ? now_reg : tick_reg;
                wdata   = {cur_now, dur_reg};
                we      = (32'(idx_reg) < NUM_SLOTS) && !used_reg[iidx];
            end
            ST_EXEC: begin
                we = exec_ok && (op_reg == OP_START || op_reg == OP_RESET);
            end
            ST_SCAN_RD: addr = iidx;
            ST_SCAN_EV: begin
                addr    = iidx;
                cur_now = units_reg[iidx] ? now_reg : tick_reg;
                wdata   = {cur_now, r_period};
                // restart only at the edge where the scan moves on
                we      = expire && repeat_reg[iidx] && (!out_v_reg || m_tready);
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0, res_reg.remaining_units, res_reg.remaining,
                       res_reg.is_active, res_reg.ok, res_reg.slot_out};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            active_reg <= '0;
            dying_reg  <= '0;
            tick_reg   <= '0;
            out_v_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= op_t'(s_tdata[2:0]);
                        slot_reg   <= s_tdata[6:3];
                        cunits_reg <= s_tdata[7];
                        dur_reg    <= s_tdata[39:8];
                        cauto_reg  <= s_tdata[40];
                        crep_reg   <= s_tdata[41];
                        now_reg    <= TIME_BITS'(s_tdata[42 +: NOW_W]);
                        idx_reg    <= '0;
                        unique case (op_t'(s_tdata[2:0]))
                            OP_CREATE: state_reg <= ST_FIND;
                            OP_TICK:   state_reg <= ST_SCAN_RD;
                            default:   state_reg <= ST_READ;
                        endcase
                    end
                end
                ST_FIND: begin
                    if (32'(idx_reg) >= NUM_SLOTS) begin
                        res_reg   <= '{kind: KIND_REPLY, slot_out: '0, ok: 1'b0,
                                       is_active: 1'b0, remaining: '0,
                                       remaining_units: 1'b0, last: 1'b1};
                        out_v_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (!used_reg[iidx]) begin
                        used_reg[iidx]   <= 1'b1;
                        dying_reg[iidx]  <= 1'b0;
                        active_reg[iidx] <= cauto_reg;
                        repeat_reg[iidx] <= crep_reg;
                        units_reg[iidx]  <= cunits_reg;
                        res_reg          <= '{kind: KIND_REPLY, slot_out: SLOT_W'(idx_reg),
                                              ok: 1'b1, is_active: 1'b0, remaining: '0,
                                              remaining_units: 1'b0, last: 1'b1};
                        out_v_reg        <= 1'b1;
                        state_reg        <= ST_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_READ: state_reg <= ST_EXEC;
                ST_EXEC: begin
                    res_reg <= '{kind: KIND_REPLY, slot_out: slot_reg, ok: exec_ok,
                                 is_active: q_act, remaining: q_act ? rem : '0,
                                 remaining_units: (op_reg == OP_QUERY) && exec_used &&
                                                  units_reg[sidx],
                                 last: 1'b1};
                    if (exec_ok) begin
                        case (op_reg)
                            OP_DESTROY: dying_reg[sidx]  <= 1'b1;
                            OP_START:   active_reg[sidx] <= 1'b1;
                            OP_STOP:    active_reg[sidx] <= 1'b0;
                            default: ;
                        endcase
                    end
                    out_v_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_SCAN_RD: begin
                    if (32'(idx_reg) >= NUM_SLOTS) begin
                        // wait for a pending expiry transfer before the reply
                        if (!out_v_reg || m_tready) begin
                            for (int i = 0; i < NUM_SLOTS; i++) begin
                                if (dying_reg[i]) begin
                                    used_reg[i]   <= 1'b0;
                                    active_reg[i] <= 1'b0;
                                    dying_reg[i]  <= 1'b0;
                                end
                            end
                            tick_reg  <= tick_reg + 1'b1;
                            res_reg   <= '{kind: KIND_REPLY, slot_out: '0, ok: 1'b1,
                                           is_active: 1'b0, remaining: '0,
                                           remaining_units: 1'b0, last: 1'b1};
                            out_v_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        if (m_tready) begin
                            out_v_reg <= 1'b0;
                        end
                        state_reg <= ST_SCAN_EV;
                    end
                end
                ST_SCAN_EV: begin
                    if (!out_v_reg || m_tready) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                        out_v_reg <= expire;
                        if (expire) begin
                            if (!repeat_reg[iidx]) begin
                                active_reg[iidx] <= 1'b0;
                            end
                            res_reg <= '{kind: KIND_EXPIRY, slot_out: SLOT_W'(idx_reg),
                                         ok: 1'b1, is_active: 1'b0, remaining: '0,
                                         remaining_units: 1'b0, last: 1'b0};
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        out_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### rtl/mset_checker.sv
// port-level checks for the timer table, bound to the top level
// depends on multi_slot_event_timer_table_unit ports
module mset_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");
    a_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[4])
        else $error("bad expiry transfer");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("result pending while ready");
endmodule

bind multi_slot_event_timer_table_unit mset_checker u_mset_checker (.*);

### verif/tb_multi_slot_event_timer_table_unit.sv
// testbench for multi_slot_event_timer_table_unit: directed and random operations
// checked against an in-bench timer table predictor; depends on rtl/mset_pkg.sv and the rtl
`timescale 1ns / 1ps

module tb_multi_slot_event_timer_table_unit;
    import mset_pkg::*;

    localparam int NS = DEF_NUM_SLOTS;
    localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    multi_slot_event_timer_table_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state of the timer table
    logic [47:0] tick_cnt;
    logic        t_used [NS];
    logic        t_active [NS];
    logic        t_repeat [NS];
    logic        t_dying [NS];
    logic        t_units [NS];
    logic [47:0] t_start [NS];
    logic [31:0] t_period [NS];

    result_t expected_results[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int expiries_seen = 0;
    int cycles = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 15;
    bit hold_req = 1'b0;
    bit recv_hold = 1'b0;
    int hold_cycles = 0;
    logic [47:0] now_stamp = 48'd0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("error: result %0d field %s got %0h want %0h", results_seen, what, got, want);
    endtask

    function automatic result_t mk(input logic kind, input logic [3:0] s, input logic ok,
                                   input logic act, input logic [31:0] rem,
                                   input logic ru, input logic lst);
        result_t r;
        r.kind = kind; r.slot_out = s; r.ok = ok; r.is_active = act;
        r.remaining = rem; r.remaining_units = ru; r.last = lst;
        return r;
    endfunction

    function automatic void add_expected(input result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [47:0] slot_now(input int i, input logic [47:0] nms);
        return t_units[i] ? nms : tick_cnt;
    endfunction

    task automatic predict_timer_op(input op_t op, input logic [3:0] s, input logic units,
                                    input logic [31:0] dur, input logic auto_st,
                                    input logic rep, input logic [47:0] nms);
        int i;
        int fr;
        logic used;
        logic ok;
        logic [47:0] nw;
        logic [47:0] el;
        logic [31:0] rem;
        used = t_used[s];
        case (op)
            OP_CREATE: begin
                fr = -1;
                for (i = NS - 1; i >= 0; i--) if (!t_used[i]) fr = i;
                if (fr < 0) begin
                    add_expected(mk(KIND_REPLY, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1));
                end else begin
                    t_used[fr] = 1'b1; t_dying[fr] = 1'b0; t_active[fr] = auto_st;
                    t_repeat[fr] = rep; t_units[fr] = units; t_period[fr] = dur;
                    t_start[fr] = units ? nms : tick_cnt;
                    add_expected(mk(KIND_REPLY, fr[3:0], 1'b1, 1'b0, 32'd0, 1'b0, 1'b1));
                end
            end
            OP_DESTROY: begin
                if (used) t_dying[s] = 1'b1;
                add_expected(mk(KIND_REPLY, s, used, 1'b0, 32'd0, 1'b0, 1'b1));
            end
            OP_START: begin
                ok = used && !t_active[s];
                if (ok) begin
                    t_start[s] = slot_now(s, nms);
                    t_active[s] = 1'b1;
                end
                add_expected(mk(KIND_REPLY, s, ok, 1'b0, 32'd0, 1'b0, 1'b1));
            end
            OP_STOP: begin
                ok = used && t_active[s];
                if (ok) t_active[s] = 1'b0;
                add_expected(mk(KIND_REPLY, s, ok, 1'b0, 32'd0, 1'b0, 1'b1));
            end
            OP_RESET: begin
                ok = used && t_active[s];
                if (ok) t_start[s] = slot_now(s, nms);
                add_expected(mk(KIND_REPLY, s, ok, 1'b0, 32'd0, 1'b0, 1'b1));
            end
            OP_QUERY: begin
                ok = used && t_active[s];
                rem = 32'd0;
                if (ok) begin
                    nw = slot_now(s, nms);
                    el = (nw >= t_start[s]) ? nw - t_start[s] : 48'd0;
                    rem = (el >= {16'd0, t_period[s]}) ? 32'd0 : t_period[s] - el[31:0];
                end
                add_expected(mk(KIND_REPLY, s, used, ok, rem, used && t_units[s], 1'b1));
            end
            OP_TICK: begin
                for (i = 0; i < NS; i++) begin
                    if (t_used[i] && !t_dying[i] && t_active[i]) begin
                        nw = slot_now(i, nms);
                        if (nw >= t_start[i] && (nw - t_start[i]) >= {16'd0, t_period[i]}) begin
                            add_expected(mk(KIND_EXPIRY, i[3:0], 1'b1, 1'b0, 32'd0,
                                            1'b0, 1'b0));
                            if (t_repeat[i]) t_start[i] = nw;
                            else t_active[i] = 1'b0;
                        end
                    end
                end
                for (i = 0; i < NS; i++) begin
                    if (t_used[i] && t_dying[i]) begin
                        t_used[i] = 1'b0; t_active[i] = 1'b0; t_dying[i] = 1'b0;
                    end
                end
                tick_cnt = (tick_cnt + 48'd1) & TMASK;
                add_expected(mk(KIND_REPLY, 4'd0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b1));
            end
            default: begin
                add_expected(mk(KIND_REPLY, s, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // one transfer on the input side, predicted when it is accepted
    task automatic send_op(input op_t op, input logic [3:0] s, input logic units,
                           input logic [31:0] dur, input logic auto_st, input logic rep,
                           input logic [47:0] nms);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {6'd0, nms, rep, auto_st, dur, units, s, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_timer_op(op, s, units, dur, auto_st, rep, nms);
        items_sent++;
    endtask

    // time advances slowly so millisecond timers actually expire
    task automatic send_simple(input op_t op, input logic [3:0] s);
        now_stamp = now_stamp + $urandom_range(8);
        send_op(op, s, 1'b0, 32'd0, 1'b0, 1'b0, now_stamp);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t w;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("error: unexpected result %0h", m_tdata);
            end else begin
                w = expected_results.pop_front();
                if (m_tuser) expiries_seen++;
                if (m_tuser !== w.kind) report_mismatch("kind", m_tuser, w.kind);
                if (m_tdata[3:0] !== w.slot_out) report_mismatch("slot_out", m_tdata[3:0], w.slot_out);
                if (m_tdata[4] !== w.ok) report_mismatch("ok", m_tdata[4], w.ok);
                if (m_tdata[5] !== w.is_active) report_mismatch("is_active", m_tdata[5], w.is_active);
                if (m_tdata[37:6] !== w.remaining)
                    report_mismatch("remaining", m_tdata[37:6], w.remaining);
                if (m_tdata[38] !== w.remaining_units)
                    report_mismatch("remaining_units", m_tdata[38], w.remaining_units);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
        end
    end

    // receiver ready, with a counted long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_hold) begin
            m_tready <= 1'b0;
            if (hold_cycles >= 400) begin
                recv_hold <= 1'b0;
                hold_cycles <= 0;
            end else begin
                hold_cycles <= hold_cycles + 1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (hold_req) recv_hold <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_extremes;
        int i;
        send_simple(OP_QUERY, 4'd0);
        send_simple(OP_TICK, 4'd15);
        send_op(OP_CREATE, 4'd0, 1'b0, 32'd0, 1'b1, 1'b1, now_stamp);
        send_op(OP_CREATE, 4'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, now_stamp);
        send_op(OP_CREATE, 4'd0, 1'b0, 32'd2, 1'b1, 1'b0, now_stamp);
        send_op(OP_CREATE, 4'd0, 1'b1, 32'd5, 1'b0, 1'b1, now_stamp);
        send_simple(OP_QUERY, 4'd1);
        send_simple(OP_QUERY, 4'd2);
        send_simple(OP_START, 4'd3);
        send_simple(OP_START, 4'd3);
        send_simple(OP_TICK, 4'd0);
        send_simple(OP_RESET, 4'd2);
        send_simple(OP_STOP, 4'd2);
        send_simple(OP_STOP, 4'd2);
        send_simple(OP_RESET, 4'd2);
        send_simple(OP_DESTROY, 4'd0);
        send_simple(OP_DESTROY, 4'd9);
        send_simple(OP_QUERY, 4'd0);
        send_simple(OP_UNDEF, 4'd5);
        send_simple(OP_TICK, 4'd0);
        // time going backwards counts as zero elapsed
        send_op(OP_QUERY, 4'd1, 1'b0, 32'd0, 1'b0, 1'b0, 48'd0);
        send_op(OP_QUERY, 4'd1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, TMASK);
        drain();
        // fill the table to see the full reply, then tick everything
        for (i = 0; i < 15; i++)
            send_op(OP_CREATE, 4'd0, i[0], 32'd1, 1'b1, i[1], now_stamp);
        send_simple(OP_TICK, 4'd0);
        drain();
    endtask

    task automatic test_backpressure;
        int i;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        for (i = 0; i < 12; i++) send_simple(OP_TICK, 4'd0);
        drain();
    endtask

    task automatic random_op;
        int r;
        logic [3:0] s;
        r = $urandom_range(99);
        s = 4'($urandom_range(15));
        now_stamp = now_stamp + $urandom_range(6);
        if (r < 20)
            send_op(OP_CREATE, s, 1'($urandom_range(1)), $urandom_range(12),
                    $urandom_range(3) != 0, 1'($urandom_range(1)), now_stamp);
        else if (r < 23)
            send_op(OP_CREATE, s, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                    1'($urandom_range(1)), 48'({$urandom, $urandom}));
        else if (r < 30) send_simple(OP_DESTROY, s);
        else if (r < 40) send_simple(OP_START, s);
        else if (r < 47) send_simple(OP_STOP, s);
        else if (r < 54) send_simple(OP_RESET, s);
        else if (r < 66) send_simple(OP_QUERY, s);
        else if (r < 97) send_simple(OP_TICK, s);
        else send_op(OP_UNDEF, s, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                     1'($urandom_range(1)), 48'({$urandom, $urandom}));
    endtask

    task automatic test_random;
        int i;
        for (i = 0; i < 100; i++) random_op();
        // calm stretch with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < 80; i++) random_op();
        send_idle_pct = 15;
        recv_idle_pct = 15;
        for (i = 0; i < 70; i++) random_op();
        drain();
    endtask

    initial begin
        int i;
        tick_cnt = '0;
        for (i = 0; i < NS; i++) begin
            t_used[i] = 1'b0; t_active[i] = 1'b0; t_dying[i] = 1'b0;
            t_repeat[i] = 1'b0; t_units[i] = 1'b0; t_start[i] = '0; t_period[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_backpressure();
        test_random();
        $display("covered %0d operations, %0d results of which %0d expiries",
                 items_sent, results_seen, expiries_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results never arrived", errors, expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/mset_pkg.sv
rtl/mset_ram.sv
rtl/mset_time_unit.sv
rtl/multi_slot_event_timer_table_unit.sv
rtl/mset_checker.sv
verif/tb_multi_slot_event_timer_table_unit.sv
